>>> sv/pcrx_pkg.sv
package pcrx_pkg;

  localparam int NumRegsDef = 24;
  localparam int WordW = 64;
  localparam int IdxW = 5;

  localparam logic ReqExtend = 1'b0;
  localparam logic ReqRead = 1'b1;
  localparam logic StatusDone = 1'b0;
  localparam logic StatusRange = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  reg_idx;
    logic [1:0]  word_pos;
    logic [63:0] data_word;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] read_word;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_RD_ADDR,
    ST_RD_DATA,
    ST_RD_OUT,
    ST_LD_ADDR,
    ST_LD_DATA,
    ST_HASH,
    ST_WB,
    ST_DONE
  } state_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic       init_iv;    // chain <= IV, schedule <= msg
    logic       load_blk;   // working <= chain, start rounds
    logic       pad_blk;    // schedule <= padding block
    logic       round;      // run one round
    logic       fold;       // chain += working
    logic [5:0] t;          // round number
  } sha_ctl_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  localparam logic [255:0] InitH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

endpackage

>>> sv/pcrx_if.sv
interface pcrx_req_if;
  logic            valid;
  logic            ready;
  pcrx_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pcrx_rsp_if;
  logic            valid;
  logic            ready;
  pcrx_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/pcr_extend_bank_core.sv
// A read gives 4 results via ST_RD_ADDR, ST_RD_DATA and ST_RD_OUT, each later one once
// the previous is taken. Extend trigger: load 4 old words, hash the message then the
// padding block, finish, write back 4 words. Early digest words are only buffered;
// out-of-range result in the cycle after accept. One request at a time; the SHA unit,
// one round a cycle, sets the extend cost. Reset: synchronous, active low; a clearing
// pass zeroes all 4*NumRegs store words before in_ready rises; digest buffer cleared.
module pcr_extend_bank_core #(
  parameter int NumRegs = pcrx_pkg::NumRegsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  pcrx_req_if.sink     in_ch,
  pcrx_rsp_if.source   out_ch
);
  localparam int Depth = 4 * NumRegs;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW1 = pcrx_pkg::IdxW + 1;

  pcrx_pkg::state_t state_r, state_nxt;
  pcrx_pkg::req_t   req_r;
  logic             clr_r;        // clearing pass in progress
  logic [AddrW:0]   clr_cnt_r;
  logic [1:0]       cnt_r;        // word counter for loads/reads/write-back
  logic [5:0]       t_r;
  logic             blk_r;        // 0 = message block, 1 = padding block
  logic             run_r;        // rounds in flight
  logic [63:0]      dbuf_r [3];
  logic [255:0]     old_r;
  logic [63:0]      rword_r;

  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [63:0]      wdata, rdata;
  logic [255:0]     chain;
  pcrx_pkg::sha_ctl_t ctl;
  logic [AddrW-1:0] base;
  logic             in_range;

  assign base = AddrW'({req_r.reg_idx, 2'b00});
  assign in_range = {1'b0, in_ch.payload.reg_idx} < IdxW1'(NumRegs);

  pcrx_ram #(.Width(64), .Depth(Depth)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  pcrx_round u_round (
    .clk, .ctl, .msg({old_r, dbuf_r[0], dbuf_r[1], dbuf_r[2], req_r.data_word}),
    .chain
  );

  assign in_ch.ready = (state_r == pcrx_pkg::ST_IDLE) && !clr_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcrx_pkg::ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (!in_range) begin
            state_nxt = pcrx_pkg::ST_RANGE;
          end else if (in_ch.payload.req_type == pcrx_pkg::ReqRead) begin
            state_nxt = pcrx_pkg::ST_RD_ADDR;
          end else if (in_ch.payload.word_pos == 2'd3) begin
            state_nxt = pcrx_pkg::ST_LD_ADDR;
          end
        end
      end
      pcrx_pkg::ST_RANGE, pcrx_pkg::ST_DONE: begin
        if (out_ch.ready) state_nxt = pcrx_pkg::ST_IDLE;
      end
      pcrx_pkg::ST_RD_ADDR: state_nxt = pcrx_pkg::ST_RD_DATA;
      pcrx_pkg::ST_RD_DATA: state_nxt = pcrx_pkg::ST_RD_OUT;
      pcrx_pkg::ST_RD_OUT: begin
        if (out_ch.ready) begin
          state_nxt = (cnt_r == 2'd3) ? pcrx_pkg::ST_IDLE : pcrx_pkg::ST_RD_ADDR;
        end
      end
      pcrx_pkg::ST_LD_ADDR: state_nxt = pcrx_pkg::ST_LD_DATA;
      pcrx_pkg::ST_LD_DATA: begin
        state_nxt = (cnt_r == 2'd3) ? pcrx_pkg::ST_HASH : pcrx_pkg::ST_LD_ADDR;
      end
      pcrx_pkg::ST_HASH: begin
        if (!run_r && blk_r && t_r == 6'd0 && ctl.fold == 1'b0 && cnt_r == 2'd1) begin
          state_nxt = pcrx_pkg::ST_WB;
        end
      end
      pcrx_pkg::ST_WB: begin
        if (cnt_r == 2'd3) state_nxt = pcrx_pkg::ST_DONE;
      end
      default: state_nxt = pcrx_pkg::ST_IDLE;
    endcase
  end

  // hash phase in cnt_r (ST_HASH): 0 set up block, 3 start rounds, 2 fold, 1 finished
  always_comb begin
    ctl = '0;
    ctl.t = t_r;
    if (state_r == pcrx_pkg::ST_HASH) begin
      if (run_r) begin
        ctl.round = 1'b1;
      end else if (cnt_r == 2'd0) begin
        ctl.init_iv  = !blk_r;
        ctl.pad_blk  = blk_r;
        ctl.load_blk = 1'b0;
      end else if (cnt_r == 2'd3) begin
        ctl.load_blk = 1'b1;
      end else if (cnt_r == 2'd2) begin
        ctl.fold = 1'b1;
      end
    end
  end

  // memory and output
  always_comb begin
    we    = 1'b0;
    waddr = base + AddrW'(cnt_r);
    wdata = chain[255-64*cnt_r -: 64];
    raddr = base + AddrW'(cnt_r);
    if (clr_r) begin
      we    = 1'b1;
      waddr = clr_cnt_r[AddrW-1:0];
      wdata = '0;
    end else if (state_r == pcrx_pkg::ST_WB) begin
      we = 1'b1;
    end
    out_ch.valid = (state_r == pcrx_pkg::ST_RANGE) || (state_r == pcrx_pkg::ST_DONE)
                || (state_r == pcrx_pkg::ST_RD_OUT);
    out_ch.payload.status    = (state_r == pcrx_pkg::ST_RANGE) ? pcrx_pkg::StatusRange
                                                              : pcrx_pkg::StatusDone;
    out_ch.payload.read_word = (state_r == pcrx_pkg::ST_RD_OUT) ? rword_r : '0;
    out_ch.payload.last      = (state_r != pcrx_pkg::ST_RD_OUT) || (cnt_r == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pcrx_pkg::ST_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
      cnt_r     <= '0;
      t_r       <= '0;
      blk_r     <= 1'b0;
      run_r     <= 1'b0;
      for (int i = 0; i < 3; i++) dbuf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AddrW+1)'(Depth - 1)) clr_r <= 1'b0;
      end
      case (state_r)
        pcrx_pkg::ST_IDLE: begin
          cnt_r <= '0;
          blk_r <= 1'b0;
          t_r   <= '0;
          if (in_ch.valid && in_ch.ready) begin
            req_r <= in_ch.payload;
            if (in_range && in_ch.payload.req_type == pcrx_pkg::ReqExtend
                && in_ch.payload.word_pos != 2'd3) begin
              dbuf_r[in_ch.payload.word_pos] <= in_ch.payload.data_word;
            end
          end
        end
        pcrx_pkg::ST_RD_DATA: rword_r <= rdata;
        pcrx_pkg::ST_RD_OUT: if (out_ch.ready) cnt_r <= cnt_r + 1'b1;
        pcrx_pkg::ST_LD_DATA: begin
          old_r[255-64*cnt_r -: 64] <= rdata;
          cnt_r <= cnt_r + 1'b1;
        end
        pcrx_pkg::ST_HASH: begin
          if (run_r) begin
            t_r <= t_r + 1'b1;
            if (t_r == 6'd63) begin
              run_r <= 1'b0;
              cnt_r <= 2'd2;
            end
          end else if (cnt_r == 2'd0) begin
            cnt_r <= 2'd3;
          end else if (cnt_r == 2'd3) begin
            run_r <= 1'b1;
          end else if (cnt_r == 2'd2) begin
            if (blk_r) begin
              cnt_r <= 2'd1;
            end else begin
              blk_r <= 1'b1;
              cnt_r <= 2'd0;
            end
          end else begin
            cnt_r <= 2'd0;
          end
        end
        pcrx_pkg::ST_WB: cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase
    end
  end
endmodule

>>> sv/pcrx_ram.sv
module pcrx_ram #(
  parameter int Width = 64,
  parameter int Depth = 96
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/pcrx_round.sv
// One SHA-256 round per cycle with a rolling 16-word schedule.
module pcrx_round (
  input  logic              clk,
  input  pcrx_pkg::sha_ctl_t ctl,
  input  logic [511:0]      msg,
  output logic [255:0]      chain
);
  logic [31:0] w_r [16];
  logic [31:0] v_r [8];
  logic [255:0] chain_r;

  logic [31:0] w15, w2, s0, s1, wt, t1, t2, e, a;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    w15 = w_r[4'(ctl.t - 6'd15)];
    w2  = w_r[4'(ctl.t - 6'd2)];
    s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
    s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
    if (ctl.t < 6'd16) begin
      wt = w_r[ctl.t[3:0]];
    end else begin
      wt = w_r[ctl.t[3:0]] + s0 + w_r[4'(ctl.t - 6'd7)] + s1;
    end
    e  = v_r[4];
    a  = v_r[0];
    t1 = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
       + ((e & v_r[5]) ^ (~e & v_r[6])) + pcrx_pkg::round_k(ctl.t) + wt;
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
       + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_ff @(posedge clk) begin
    if (ctl.init_iv) begin
      chain_r <= pcrx_pkg::InitH;
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= msg[511-32*i -: 32];
      end
    end
    if (ctl.pad_blk) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= '0;
      end
      w_r[0]  <= 32'h80000000;
      w_r[15] <= 32'd512;
    end
    if (ctl.load_blk) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= chain_r[255-32*i -: 32];
      end
    end
    if (ctl.round) begin
      if (ctl.t >= 6'd16) begin
        w_r[ctl.t[3:0]] <= wt;
      end
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (ctl.fold) begin
      for (int i = 0; i < 8; i++) begin
        chain_r[255-32*i -: 32] <= chain_r[255-32*i -: 32] + v_r[i];
      end
    end
  end

  assign chain = chain_r;
endmodule

>>> sv/pcrx_checker.sv
module pcrx_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input pcrx_pkg::rsp_t out_payload
);
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while result pending");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.status == pcrx_pkg::StatusRange |->
      out_payload.last && out_payload.read_word == '0)
    else $error("range error result malformed");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready || !out_valid)
    else $error("ready after accept with result pending");
endmodule

bind pcr_extend_bank_core pcrx_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_payload(out_ch.payload)
);

>>> tb/pcr_extend_bank_checker.sv
`timescale 1ns / 100ps
module pcr_extend_bank_checker #(
  parameter int NumRegs = pcrx_pkg::NumRegsDef
) (
  input  logic clk,
  input  logic rst_n,
  input  logic req_valid,
  input  logic req_ready,
  input  pcrx_pkg::req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  pcrx_pkg::rsp_t rsp,
  output int   fail_count,
  output int   pending_rsp,
  output int   rsp_seen
);
  logic [255:0]   pcr_bank [NumRegs];
  logic [63:0]    digest_hold [3];
  pcrx_pkg::rsp_t rsp_queue [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one compression of a 512-bit block into the chaining value
  function automatic logic [255:0] sha_block(input logic [255:0] chain_in,
                                             input logic [511:0] blk);
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] ch [8];
    logic [31:0] wt, t1, t2, s0, s1, w15, w2;
    logic [255:0] res;
    for (int i = 0; i < 8; i++) begin
      ch[i] = chain_in[255 - 32 * i -: 32];
      v[i] = ch[i];
    end
    for (int i = 0; i < 16; i++) w[i] = blk[511 - 32 * i -: 32];
    for (int t = 0; t < 64; t++) begin
      if (t < 16) begin
        wt = w[t];
      end else begin
        w15 = w[(t - 15) & 15];
        w2 = w[(t - 2) & 15];
        s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        wt = w[t & 15] + s0 + w[(t - 7) & 15] + s1;
        w[t & 15] = wt;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + pcrx_pkg::round_k(6'(t)) + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) res[255 - 32 * i -: 32] = ch[i] + v[i];
    return res;
  endfunction

  function automatic logic [255:0] pcr_extended(input logic [255:0] old_val,
                                                input logic [255:0] digest);
    logic [255:0] h;
    h = sha_block(pcrx_pkg::InitH, {old_val, digest});
    return sha_block(h, {32'h80000000, 448'd0, 32'd512});
  endfunction

  task automatic predict_request(input pcrx_pkg::req_t r);
    pcrx_pkg::rsp_t e;
    if (r.reg_idx >= NumRegs) begin
      e = '{status: pcrx_pkg::StatusRange, read_word: '0, last: 1'b1};
      rsp_queue.push_back(e);
    end else if (r.req_type == pcrx_pkg::ReqRead) begin
      for (int i = 0; i < 4; i++) begin
        e = '{status: pcrx_pkg::StatusDone,
              read_word: pcr_bank[r.reg_idx][255 - 64 * i -: 64],
              last: (i == 3)};
        rsp_queue.push_back(e);
      end
    end else if (r.word_pos != 2'd3) begin
      digest_hold[r.word_pos] = r.data_word;
    end else begin
      pcr_bank[r.reg_idx] = pcr_extended(pcr_bank[r.reg_idx],
          {digest_hold[0], digest_hold[1], digest_hold[2], r.data_word});
      e = '{status: pcrx_pkg::StatusDone, read_word: '0, last: 1'b1};
      rsp_queue.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    pcrx_pkg::rsp_t e;
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) pcr_bank[i] = '0;
      for (int i = 0; i < 3; i++) digest_hold[i] = '0;
      rsp_queue.delete();
      fail_count = 0;
      rsp_seen = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_seen++;
        if (rsp_queue.size() == 0) begin
          $error("unexpected response %p", rsp);
          fail_count++;
        end else begin
          e = rsp_queue.pop_front();
          if (rsp.status !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, rsp.status);
            fail_count++;
          end
          if (rsp.read_word !== e.read_word) begin
            $error("read_word: expected %h actual %h", e.read_word, rsp.read_word);
            fail_count++;
          end
          if (rsp.last !== e.last) begin
            $error("last: expected %0d actual %0d", e.last, rsp.last);
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) predict_request(req);
    end
    pending_rsp = rsp_queue.size();
  end
endmodule

>>> tb/pcr_extend_bank_core_tb.sv
`timescale 1ns / 100ps
module pcr_extend_bank_core_tb;

  localparam int NumRandom = 84;
  // idle-cycle limit; covers the reset clearing pass and a full extend
  localparam int StallLimit = 5000;

  logic clk;
  logic rst_n;
  int   fail_count, pending_rsp, rsp_seen;
  int   send_idle_pct, recv_idle_pct;
  bit   hold_off;   // long receiver stall to back the block up
  bit   stim_done;
  int   n_requests;

  pcrx_req_if req_ch ();
  pcrx_rsp_if rsp_ch ();

  pcr_extend_bank_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch.sink),
    .out_ch (rsp_ch.source)
  );

  pcr_extend_bank_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req         (req_ch.payload),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp         (rsp_ch.payload),
    .fail_count  (fail_count),
    .pending_rsp (pending_rsp),
    .rsp_seen    (rsp_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random backpressure, or a long hold-off when asked
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles with no request or response moving
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("timeout after %0d idle cycles", quiet);
        $display("pcr_extend_bank_core_tb failed");
        $finish;
      end
    end
  end

  // offer one request, with random idle cycles before it per current mix
  task automatic send_request(input logic rt, input logic [4:0] idx,
                              input logic [1:0] pos, input logic [63:0] dw);
    pcrx_pkg::req_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    r.req_type = rt;
    r.reg_idx = idx;
    r.word_pos = pos;
    r.data_word = dw;
    req_ch.valid <= 1'b1;
    req_ch.payload <= r;
    do @(posedge clk); while (!req_ch.ready);
    n_requests++;
  endtask

  // full four-word extend with random digest
  task automatic send_extend(input logic [4:0] idx);
    for (int p = 0; p < 4; p++)
      send_request(pcrx_pkg::ReqExtend, idx, 2'(p), {$urandom, $urandom});
  endtask

  task automatic random_request();
    int sel;
    logic [4:0] idx;
    sel = $urandom_range(99);
    idx = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(23));
    if (sel < 45) send_extend(idx);
    else if (sel < 75) send_request(pcrx_pkg::ReqRead, idx, 2'($urandom),
                                    {$urandom, $urandom});
    else send_request(pcrx_pkg::ReqExtend, idx, 2'($urandom),
                      {$urandom, $urandom}); // broken seq
  endtask

  initial begin
    rst_n = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    n_requests = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reads of cleared registers, extremes, out-of-range, odd orders
    send_request(pcrx_pkg::ReqRead, 5'd0, 2'd0, '0);
    send_request(pcrx_pkg::ReqRead, 5'd23, 2'd3, '1);
    send_request(pcrx_pkg::ReqExtend, 5'd0, 2'd3, '0);          // trigger with reset buffer
    send_request(pcrx_pkg::ReqRead, 5'd0, 2'd0, '0);
    send_request(pcrx_pkg::ReqExtend, 5'd23, 2'd0, '1);
    send_request(pcrx_pkg::ReqExtend, 5'd23, 2'd1, 64'h0123456789abcdef);
    send_request(pcrx_pkg::ReqExtend, 5'd23, 2'd2, 64'h8000000000000001);
    send_request(pcrx_pkg::ReqExtend, 5'd23, 2'd3, '1);
    send_request(pcrx_pkg::ReqRead, 5'd23, 2'd1, '0);
    send_request(pcrx_pkg::ReqExtend, 5'd24, 2'd0, '1);         // out of range
    send_request(pcrx_pkg::ReqExtend, 5'd31, 2'd3, '1);
    send_request(pcrx_pkg::ReqRead, 5'd31, 2'd0, '0);
    send_request(pcrx_pkg::ReqRead, 5'd24, 2'd2, '0);
    send_request(pcrx_pkg::ReqExtend, 5'd5, 2'd2, 64'hdeadbeefcafef00d); // out of order
    send_request(pcrx_pkg::ReqExtend, 5'd5, 2'd0, '0);
    send_request(pcrx_pkg::ReqExtend, 5'd7, 2'd3, 64'h5555aaaa5555aaaa); // other index
    send_request(pcrx_pkg::ReqRead, 5'd7, 2'd0, '0);
    send_request(pcrx_pkg::ReqRead, 5'd5, 2'd0, '0);

    // long receiver hold-off while reads keep coming
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_request(pcrx_pkg::ReqRead, 5'(i), 2'd0, '0);
    join

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 61 : 0;
      recv_idle_pct = (ph == 0) ? 61 : (ph == 1) ? 14 : 0;
      for (int i = 0; i < NumRandom / 3; i++) random_request();
    end
    req_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int drain;
    wait (stim_done);
    drain = 0;
    while (pending_rsp != 0 && drain < 20 * StallLimit) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    $display("covered %0d requests and %0d responses: extends, reads, out-of-range,",
             n_requests, rsp_seen);
    $display("broken digest sequences, and send/receive stall mixes with a long hold-off");
    if (fail_count == 0 && pending_rsp == 0) begin
      $display("pcr_extend_bank_core_tb passed");
    end else begin
      $display("pcr_extend_bank_core_tb failed");
    end
    $finish;
  end
endmodule

>>> pcr_extend_bank_core.f
sv/pcrx_pkg.sv
sv/pcrx_if.sv
sv/pcrx_ram.sv
sv/pcrx_round.sv
sv/pcr_extend_bank_core.sv
sv/pcrx_checker.sv
tb/pcr_extend_bank_checker.sv
tb/pcr_extend_bank_core_tb.sv
